/* rtl/core/slcfd_pkg.sv */
// shared types and constants for the sync / length / crc frame deframer
package slcfd_pkg;

  // frame layout: two sync bytes, then ten more header bytes, then payload
  localparam logic [10:0] POS_HUNT     = 11'd0;
  localparam logic [10:0] POS_SYNC2    = 11'd1;
  localparam logic [10:0] POS_VERSION  = 11'd2;
  localparam logic [10:0] POS_TYPE     = 11'd3;
  localparam logic [10:0] POS_SPARE0   = 11'd4;
  localparam logic [10:0] POS_SPARE1   = 11'd5;
  localparam logic [10:0] POS_SEQ_LO   = 11'd6;
  localparam logic [10:0] POS_SEQ_HI   = 11'd7;
  localparam logic [10:0] POS_LEN_LO   = 11'd8;
  localparam logic [10:0] POS_LEN_HI   = 11'd9;
  localparam logic [10:0] POS_CRC_LO   = 11'd10;
  localparam logic [10:0] POS_CRC_HI   = 11'd11;
  localparam logic [10:0] HDR_BYTES    = 11'd12;

  localparam logic [15:0] MAX_PAYLOAD  = 16'd1024;
  localparam logic [10:0] LEN_SAT      = 11'h7FF;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h1021;

  // configuration register indexes
  localparam logic [1:0]  CFG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0]  CFG_SYNC_SECOND = 2'd1;
  localparam logic [1:0]  CFG_VERSION     = 2'd2;

  typedef enum logic [2:0] {
    DROP_NONE    = 3'd0,
    DROP_SYNC2   = 3'd1,
    DROP_LENGTH  = 3'd2,
    DROP_VERSION = 3'd3,
    DROP_CRC     = 3'd4
  } drop_reason_t;

  typedef struct packed {
    logic init;
    logic update;
  } crc_ctrl_t;

  typedef struct packed {
    logic         payload_valid;
    logic [7:0]   payload_byte;
    logic [9:0]   payload_index;
    logic         frame_end;
    logic         frame_good;
    drop_reason_t drop_reason;
    logic [7:0]   frame_type;
    logic [15:0]  frame_seq;
    logic [10:0]  frame_len;
  } result_t;

endpackage

/* rtl/core/slcfd_in_if.sv */
// received byte channel
interface slcfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/core/slcfd_out_if.sv */
// deframer result channel
interface slcfd_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [9:0]  payload_index;
  logic        frame_end;
  logic        frame_good;
  logic [2:0]  drop_reason;
  logic [7:0]  frame_type;
  logic [15:0] frame_seq;
  logic [10:0] frame_len;

  modport source (
    output valid, output payload_valid, output payload_byte, output payload_index,
    output frame_end, output frame_good, output drop_reason, output frame_type,
    output frame_seq, output frame_len, input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_byte, input payload_index,
    input frame_end, input frame_good, input drop_reason, input frame_type,
    input frame_seq, input frame_len, output ready
  );
endinterface

/* rtl/core/sync_length_crc_frame_deframer.sv */
// top level of the sync / header / length / crc-16 frame deframer
//
//  channel  | dir | transfer             | contents
//  ---------+-----+----------------------+--------------------------------------------
//  in_ch    | in  | valid && ready       | rx_byte, one received link byte
//  out_ch   | out | valid && ready       | payload byte/index, frame end, status, header
//  cfg_*    | in  | cfg_we               | sync_first, sync_second, protocol_version
//
// one byte per cycle while in_ch.ready is high: each accepted byte is decoded in a
// single pass and its result lands in the output register on the same edge
// the result is valid in the cycle after the input transfer
// in_ch.ready is high while the output register is empty or being emptied,
// so a stalled consumer holds back at most one result
// synchronous reset returns the deframer to hunting for the first sync byte
module sync_length_crc_frame_deframer import slcfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  slcfd_in_if.sink    in_ch,
  slcfd_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  // configuration registers
  logic [7:0]  sync_first_r;
  logic [7:0]  sync_second_r;
  logic [7:0]  proto_ver_r;

  // frame position: 0 hunting, 1 second sync, 2..11 header, 12 and up on payload
  logic [10:0] pos_r, pos_nxt;

  // captured header fields
  logic [7:0]  hdr_ver_r, hdr_ver_nxt;
  logic [7:0]  hdr_type_r, hdr_type_nxt;
  logic [15:0] hdr_seq_r, hdr_seq_nxt;
  logic [15:0] hdr_len_r, hdr_len_nxt;
  logic [15:0] hdr_crc_r, hdr_crc_nxt;

  // output register
  logic        out_valid_r;
  result_t     res_r, res_nxt;

  logic        in_fire;
  logic [7:0]  rx;
  logic [10:0] pay_idx;
  logic [10:0] len_sat;
  crc_ctrl_t   crc_ctrl;
  crc_ctrl_t   crc_ctrl_fire;
  logic [15:0] crc_cur;
  logic [15:0] crc_upd;

  // accept while the result register is free or drains this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign rx          = in_ch.rx_byte;

  assign pay_idx = pos_r - HDR_BYTES;
  assign len_sat = (hdr_len_r[15:11] != 5'd0) ? LEN_SAT : hdr_len_r[10:0];

  function automatic drop_reason_t end_reason(input logic ver_ok, input logic crc_ok);
    drop_reason_t r;
    if (!ver_ok) begin
      r = DROP_VERSION;
    end else if (!crc_ok) begin
      r = DROP_CRC;
    end else begin
      r = DROP_NONE;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // per-byte decode: next position, header capture and the result item
  // ---------------------------------------------------------------------------
  always_comb begin
    pos_nxt      = pos_r;
    hdr_ver_nxt  = hdr_ver_r;
    hdr_type_nxt = hdr_type_r;
    hdr_seq_nxt  = hdr_seq_r;
    hdr_len_nxt  = hdr_len_r;
    hdr_crc_nxt  = hdr_crc_r;
    crc_ctrl     = '0;
    res_nxt      = '0;

    case (pos_r)
      POS_HUNT: begin
        if (rx == sync_first_r) begin
          pos_nxt       = POS_SYNC2;
          crc_ctrl.init = 1'b1;
        end
      end
      POS_SYNC2: begin
        // a mismatching second byte abandons the hunt; it is not retried as a first sync
        if (rx != sync_second_r) begin
          pos_nxt             = POS_HUNT;
          res_nxt.frame_end   = 1'b1;
          res_nxt.drop_reason = DROP_SYNC2;
        end else begin
          pos_nxt = POS_VERSION;
        end
      end
      POS_VERSION: begin
        hdr_ver_nxt = rx;
        pos_nxt     = pos_r + 11'd1;
      end
      POS_TYPE: begin
        hdr_type_nxt = rx;
        pos_nxt      = pos_r + 11'd1;
      end
      POS_SPARE0, POS_SPARE1: begin
        pos_nxt = pos_r + 11'd1;
      end
      POS_SEQ_LO: begin
        hdr_seq_nxt = {hdr_seq_r[15:8], rx};
        pos_nxt     = pos_r + 11'd1;
      end
      POS_SEQ_HI: begin
        hdr_seq_nxt = {rx, hdr_seq_r[7:0]};
        pos_nxt     = pos_r + 11'd1;
      end
      POS_LEN_LO: begin
        hdr_len_nxt = {hdr_len_r[15:8], rx};
        pos_nxt     = pos_r + 11'd1;
      end
      POS_LEN_HI: begin
        hdr_len_nxt = {rx, hdr_len_r[7:0]};
        pos_nxt     = pos_r + 11'd1;
      end
      POS_CRC_LO: begin
        hdr_crc_nxt = {hdr_crc_r[15:8], rx};
        pos_nxt     = pos_r + 11'd1;
      end
      POS_CRC_HI: begin
        // header complete: length check, or an empty frame ends right here
        hdr_crc_nxt = {rx, hdr_crc_r[7:0]};
        pos_nxt     = HDR_BYTES;
        if (hdr_len_r > MAX_PAYLOAD) begin
          pos_nxt             = POS_HUNT;
          res_nxt.frame_end   = 1'b1;
          res_nxt.drop_reason = DROP_LENGTH;
          res_nxt.frame_type  = hdr_type_r;
          res_nxt.frame_seq   = hdr_seq_r;
          res_nxt.frame_len   = len_sat;
        end else if (hdr_len_r == 16'd0) begin
          pos_nxt             = POS_HUNT;
          res_nxt.frame_end   = 1'b1;
          res_nxt.drop_reason = end_reason(hdr_ver_r == proto_ver_r,
                                           crc_cur == {rx, hdr_crc_r[7:0]});
          res_nxt.frame_good  = (res_nxt.drop_reason == DROP_NONE);
          res_nxt.frame_type  = hdr_type_r;
          res_nxt.frame_seq   = hdr_seq_r;
          res_nxt.frame_len   = len_sat;
        end
      end
      default: begin
        // payload byte: pass it on and fold it into the crc
        crc_ctrl.update       = 1'b1;
        pos_nxt               = pos_r + 11'd1;
        res_nxt.payload_valid = 1'b1;
        res_nxt.payload_byte  = rx;
        res_nxt.payload_index = pay_idx[9:0];
        res_nxt.frame_type    = hdr_type_r;
        res_nxt.frame_seq     = hdr_seq_r;
        res_nxt.frame_len     = len_sat;
        if (({5'd0, pay_idx} + 16'd1) >= hdr_len_r) begin
          pos_nxt             = POS_HUNT;
          res_nxt.frame_end   = 1'b1;
          res_nxt.drop_reason = end_reason(hdr_ver_r == proto_ver_r,
                                           crc_upd == hdr_crc_r);
          res_nxt.frame_good  = (res_nxt.drop_reason == DROP_NONE);
        end
      end
    endcase
  end

  // crc only moves on an accepted byte
  assign crc_ctrl_fire = in_fire ? crc_ctrl : '0;

  slcfd_crc16 u_crc (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (crc_ctrl_fire),
    .data    (rx),
    .crc     (crc_cur),
    .crc_upd (crc_upd)
  );

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= 8'd0;
      sync_second_r <= 8'd0;
      proto_ver_r   <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
        CFG_SYNC_SECOND: sync_second_r <= cfg_wdata;
        CFG_VERSION:     proto_ver_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // frame state and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_HUNT;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        pos_r       <= pos_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // header fields are always rewritten before they are used
  always_ff @(posedge clk) begin
    if (in_fire) begin
      hdr_ver_r  <= hdr_ver_nxt;
      hdr_type_r <= hdr_type_nxt;
      hdr_seq_r  <= hdr_seq_nxt;
      hdr_len_r  <= hdr_len_nxt;
      hdr_crc_r  <= hdr_crc_nxt;
      res_r      <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.payload_valid = res_r.payload_valid;
  assign out_ch.payload_byte  = res_r.payload_byte;
  assign out_ch.payload_index = res_r.payload_index;
  assign out_ch.frame_end     = res_r.frame_end;
  assign out_ch.frame_good    = res_r.frame_good;
  assign out_ch.drop_reason   = res_r.drop_reason;
  assign out_ch.frame_type    = res_r.frame_type;
  assign out_ch.frame_seq     = res_r.frame_seq;
  assign out_ch.frame_len     = res_r.frame_len;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a good frame is always a finished frame with no drop reason
  a_good_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.frame_good |-> res_r.frame_end && res_r.drop_reason == DROP_NONE)
    else $error("frame_good without a clean frame end");

  // second sync mismatch sends the deframer straight back to hunting
  a_sync2_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && pos_r == POS_SYNC2 && rx != sync_second_r |=> pos_r == POS_HUNT)
    else $error("second sync mismatch did not return to hunt");

  // position never runs beyond the last possible payload byte
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < HDR_BYTES + MAX_PAYLOAD[10:0])
    else $error("frame position out of range");

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with empty output register");

endmodule

/* rtl/core/slcfd_crc16.sv */
// running crc-16/ccitt-false over payload bytes, one byte per cycle while ctrl.update is set
module slcfd_crc16 import slcfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  crc_ctrl_t   ctrl,
  input  logic [7:0]  data,
  output logic [15:0] crc,
  output logic [15:0] crc_upd
);

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;

  // bitwise msb-first update, eight narrow steps
  always_comb begin
    logic [15:0] c;
    c = crc_r ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_upd = c;
  end

  always_comb begin
    crc_nxt = crc_r;
    if (ctrl.init) begin
      crc_nxt = CRC_INIT;
    end else if (ctrl.update) begin
      crc_nxt = crc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign crc = crc_r;

endmodule

/* tb/sync_length_crc_frame_deframer_test.sv */
// testbench for the sync / header / length / crc-16 frame deframer
`timescale 1ns / 100ps

import slcfd_pkg::*;

class deframer_scoreboard;
  logic [7:0]  sync_first_reg;
  logic [7:0]  sync_second_reg;
  logic [7:0]  version_reg;

  logic [10:0] byte_pos;
  logic [7:0]  hdr_version;
  logic [7:0]  hdr_type;
  logic [15:0] hdr_seq;
  logic [15:0] hdr_length;
  logic [15:0] hdr_crc;
  logic [15:0] payload_crc;

  result_t     expected_results[$];
  int unsigned mismatch_count;

  function new();
    sync_first_reg  = '0;
    sync_second_reg = '0;
    version_reg     = '0;
    byte_pos        = POS_HUNT;
    hdr_version     = '0;
    hdr_type        = '0;
    hdr_seq         = '0;
    hdr_length      = '0;
    hdr_crc         = '0;
    payload_crc     = CRC_INIT;
    mismatch_count  = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [7:0] value);
    case (idx)
      CFG_SYNC_FIRST:  sync_first_reg = value;
      CFG_SYNC_SECOND: sync_second_reg = value;
      CFG_VERSION:     version_reg = value;
      default: ;
    endcase
  endfunction

  // crc-16/ccitt-false, msb first
  static function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    int k;
    c = crc ^ {data, 8'h00};
    for (k = 0; k < 8; k++)
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  function void add_header(inout result_t r);
    r.frame_type = hdr_type;
    r.frame_seq  = hdr_seq;
    r.frame_len  = (hdr_length > 16'd2047) ? LEN_SAT : hdr_length[10:0];
  endfunction

  // version is checked before crc
  function void close_frame(inout result_t r);
    r.frame_end = 1'b1;
    if (hdr_version != version_reg)
      r.drop_reason = DROP_VERSION;
    else if (payload_crc != hdr_crc)
      r.drop_reason = DROP_CRC;
    else
      r.frame_good = 1'b1;
    byte_pos = POS_HUNT;
  endfunction

  function void note_rx_byte(logic [7:0] b);
    result_t     r;
    logic [10:0] idx;
    r = '0;
    if (byte_pos == POS_HUNT) begin
      if (b == sync_first_reg) begin
        byte_pos    = POS_SYNC2;
        payload_crc = CRC_INIT;
      end
    end else if (byte_pos == POS_SYNC2) begin
      if (b != sync_second_reg) begin
        byte_pos      = POS_HUNT;
        r.frame_end   = 1'b1;
        r.drop_reason = DROP_SYNC2;
      end else begin
        byte_pos = POS_VERSION;
      end
    end else if (byte_pos < HDR_BYTES) begin
      case (byte_pos)
        POS_VERSION: hdr_version = b;
        POS_TYPE:    hdr_type = b;
        POS_SEQ_LO:  hdr_seq[7:0] = b;
        POS_SEQ_HI:  hdr_seq[15:8] = b;
        POS_LEN_LO:  hdr_length[7:0] = b;
        POS_LEN_HI:  hdr_length[15:8] = b;
        POS_CRC_LO:  hdr_crc[7:0] = b;
        POS_CRC_HI:  hdr_crc[15:8] = b;
        default: ;
      endcase
      byte_pos = byte_pos + 11'd1;
      if (byte_pos == HDR_BYTES) begin
        if (hdr_length > MAX_PAYLOAD) begin
          add_header(r);
          r.frame_end   = 1'b1;
          r.drop_reason = DROP_LENGTH;
          byte_pos      = POS_HUNT;
        end else if (hdr_length == 16'd0) begin
          add_header(r);
          close_frame(r);
        end
      end
    end else begin
      idx         = byte_pos - HDR_BYTES;
      payload_crc = crc_update(payload_crc, b);
      add_header(r);
      r.payload_valid = 1'b1;
      r.payload_byte  = b;
      r.payload_index = idx[9:0];
      byte_pos = byte_pos + 11'd1;
      if ({5'd0, idx} + 16'd1 >= hdr_length)
        close_frame(r);
    end
    expected_results.push_back(r);
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result at %0t: byte=%02h end=%0d reason=%0d",
                 $realtime, got.payload_byte, got.frame_end, got.drop_reason);
      return;
    end
    want = expected_results.pop_front();
    if (got.payload_valid !== want.payload_valid || got.payload_byte !== want.payload_byte ||
        got.payload_index !== want.payload_index || got.frame_end !== want.frame_end ||
        got.frame_good !== want.frame_good || got.drop_reason !== want.drop_reason ||
        got.frame_type !== want.frame_type || got.frame_seq !== want.frame_seq ||
        got.frame_len !== want.frame_len) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("result mismatch at %0t", $realtime);
        $display("  expected: pv=%0d byte=%02h idx=%0d end=%0d good=%0d reason=%0d",
                 want.payload_valid, want.payload_byte, want.payload_index,
                 want.frame_end, want.frame_good, want.drop_reason);
        $display("            type=%02h seq=%04h len=%0d",
                 want.frame_type, want.frame_seq, want.frame_len);
        $display("  actual:   pv=%0d byte=%02h idx=%0d end=%0d good=%0d reason=%0d",
                 got.payload_valid, got.payload_byte, got.payload_index,
                 got.frame_end, got.frame_good, got.drop_reason);
        $display("            type=%02h seq=%04h len=%0d",
                 got.frame_type, got.frame_seq, got.frame_len);
      end
    end
  endfunction
endclass

module sync_length_crc_frame_deframer_test;

  // cycles with no transfer on either channel before the run is abandoned
  localparam int WATCHDOG_LIMIT = 500;
  localparam int PHASE_BYTES    = 130;
  localparam int BIG_PAYLOAD    = 200;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_VERSION,
    FRAME_BAD_CRC,
    FRAME_OVERSIZE,
    FRAME_SYNC_MISS
  } frame_kind_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  slcfd_in_if  in_ch ();
  slcfd_out_if out_ch ();

  sync_length_crc_frame_deframer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  deframer_scoreboard sb = new();

  // settings currently loaded into the block, used to build frames
  logic [7:0] cur_sync_first;
  logic [7:0] cur_sync_second;
  logic [7:0] cur_version;

  // idling controls, cleared for the quiet tail of the run
  bit sender_idles;
  bit receiver_idles;
  bit quiet_tail;

  int bytes_sent;
  int quiet_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // consumer side: ready drops in random bursts, changed on the falling edge
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ch.ready = 1'b0;
        hold--;
      end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        hold = $urandom_range(0, 3);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // every result transfer is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_result(result_t'({out_ch.payload_valid, out_ch.payload_byte,
                                 out_ch.payload_index, out_ch.frame_end, out_ch.frame_good,
                                 out_ch.drop_reason, out_ch.frame_type, out_ch.frame_seq,
                                 out_ch.frame_len}));
  end

  // watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // one byte transfer; an optional idle gap goes in front of it
  task automatic send_byte(input logic [7:0] b);
    int gap;
    @(negedge clk);
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.rx_byte = b;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sb.note_rx_byte(b);
    bytes_sent++;
  endtask

  // hold the sender off until every predicted result has been taken
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    // a little margin after the last result is taken
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  // registers only change with the block idle
  task automatic load_config(input logic [7:0] s1, input logic [7:0] s2,
                             input logic [7:0] ver);
    drain();
    write_reg(CFG_SYNC_FIRST, s1);
    write_reg(CFG_SYNC_SECOND, s2);
    write_reg(CFG_VERSION, ver);
    @(negedge clk);
    cfg_we = 1'b0;
    cur_sync_first  = s1;
    cur_sync_second = s2;
    cur_version     = ver;
  endtask

  // builds one frame of the given kind with random content and sends it
  task automatic push_link_frame(input frame_kind_t kind, input int plen);
    logic [7:0]  frame_q[$];
    logic [7:0]  payload_q[$];
    logic [7:0]  pb;
    logic [7:0]  ver;
    logic [15:0] crc;
    logic [15:0] len_field;
    logic [15:0] seq;
    int i;

    frame_q.push_back(cur_sync_first);
    if (kind == FRAME_SYNC_MISS) begin
      // the broken second byte is sometimes the first sync value, which
      // must not restart the hunt
      if (cur_sync_first != cur_sync_second && $urandom_range(0, 1) == 1) begin
        pb = cur_sync_first;
      end else begin
        pb = 8'($urandom);
        if (pb == cur_sync_second)
          pb = ~cur_sync_second;
      end
      frame_q.push_back(pb);
    end else begin
      crc = CRC_INIT;
      if (kind != FRAME_OVERSIZE) begin
        for (i = 0; i < plen; i++) begin
          pb = 8'($urandom);
          payload_q.push_back(pb);
          crc = sb.crc_update(crc, pb);
        end
      end
      len_field = 16'(plen);
      if (kind == FRAME_OVERSIZE) begin
        case ($urandom_range(0, 2))
          0:       len_field = 16'd1025;
          1:       len_field = 16'hFFFF;
          default: len_field = 16'($urandom_range(1026, 65534));
        endcase
      end
      ver = cur_version;
      if (kind == FRAME_BAD_VERSION) begin
        ver = cur_version ^ 8'($urandom_range(1, 255));
        // half of these also carry a bad crc, version still wins
        if ($urandom_range(0, 1) == 1)
          crc = crc ^ 16'($urandom_range(1, 65535));
      end
      if (kind == FRAME_BAD_CRC)
        crc = crc ^ 16'($urandom_range(1, 65535));
      seq = 16'($urandom);
      frame_q.push_back(cur_sync_second);
      frame_q.push_back(ver);
      frame_q.push_back(8'($urandom));
      frame_q.push_back(8'($urandom));
      frame_q.push_back(8'($urandom));
      frame_q.push_back(seq[7:0]);
      frame_q.push_back(seq[15:8]);
      frame_q.push_back(len_field[7:0]);
      frame_q.push_back(len_field[15:8]);
      frame_q.push_back(crc[7:0]);
      frame_q.push_back(crc[15:8]);
      foreach (payload_q[j])
        frame_q.push_back(payload_q[j]);
    end
    foreach (frame_q[j])
      send_byte(frame_q[j]);
  endtask

  // one setting of the registers, then random frames with noise in between
  task automatic run_phase(input logic [7:0] s1, input logic [7:0] s2,
                           input logic [7:0] ver, input bit with_max_frame);
    int          start;
    int          goal;
    int          noise;
    int          pick;
    int          plen;
    logic [7:0]  nb;
    frame_kind_t kind;

    load_config(s1, s2, ver);
    start = bytes_sent;
    goal  = PHASE_BYTES;
    if (with_max_frame) begin
      // one long frame, well past the short random payloads
      sender_idles   = !quiet_tail;
      receiver_idles = !quiet_tail;
      push_link_frame(FRAME_GOOD, BIG_PAYLOAD);
      goal = goal + 12 + BIG_PAYLOAD;
    end
    while (bytes_sent - start < goal) begin
      sender_idles   = !quiet_tail && ($urandom_range(0, 3) != 0);
      receiver_idles = !quiet_tail && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 24) == 0)
        drain();

      // line noise, mostly kept clear of the first sync value
      noise = $urandom_range(0, 3);
      repeat (noise) begin
        nb = 8'($urandom);
        if (nb == cur_sync_first && $urandom_range(0, 3) != 0)
          nb = nb ^ 8'h01;
        send_byte(nb);
      end

      pick = $urandom_range(0, 99);
      if (pick < 62)      kind = FRAME_GOOD;
      else if (pick < 72) kind = FRAME_BAD_VERSION;
      else if (pick < 82) kind = FRAME_BAD_CRC;
      else if (pick < 90) kind = FRAME_OVERSIZE;
      else                kind = FRAME_SYNC_MISS;

      // mostly short payloads, zero length now and then
      pick = $urandom_range(0, 99);
      if (pick < 15)      plen = 0;
      else if (pick < 80) plen = $urandom_range(1, 8);
      else if (pick < 96) plen = $urandom_range(9, 40);
      else                plen = $urandom_range(41, 150);
      push_link_frame(kind, plen);
    end
  endtask

  initial begin
    logic [7:0] directed_bytes[$];

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_SYNC_FIRST;
    cfg_wdata      = 8'h00;
    in_ch.valid    = 1'b0;
    in_ch.rx_byte  = 8'h00;
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    quiet_tail     = 1'b0;
    bytes_sent     = 0;
    quiet_cycles   = 0;
    cur_sync_first  = 8'h00;
    cur_sync_second = 8'h00;
    cur_version     = 8'h00;

    // reset held at the start, released on a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part: byte extremes outside a frame, a second sync mismatch,
    // a mismatch on the first sync value (not re-examined), then a good
    // zero length frame whose crc field is the crc initial value
    load_config(8'hA5, 8'h5A, 8'h01);
    directed_bytes = '{8'h00, 8'hFF,
                       8'hA5, 8'h00,
                       8'hA5, 8'hA5, 8'h5A,
                       8'hA5, 8'h5A, 8'h01, 8'h07, 8'h00, 8'h00,
                       8'h34, 8'h12, 8'h00, 8'h00, 8'hFF, 8'hFF};
    foreach (directed_bytes[j])
      send_byte(directed_bytes[j]);

    // random part over several register settings, extremes among them
    run_phase(8'h55, 8'hAA, 8'h03, 1'b1);
    run_phase(8'h00, 8'h00, 8'h00, 1'b0);
    run_phase(8'hFF, 8'hFF, 8'hFF, 1'b0);
    run_phase(8'hFF, 8'h00, 8'h80, 1'b0);
    quiet_tail = 1'b1;
    run_phase(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);

    // wait out every outstanding result, then the latency
    drain();
    repeat (4) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.expected_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

/* sync_length_crc_frame_deframer.f */
rtl/core/slcfd_pkg.sv
rtl/core/slcfd_in_if.sv
rtl/core/slcfd_out_if.sv
rtl/core/slcfd_crc16.sv
rtl/core/sync_length_crc_frame_deframer.sv
tb/sync_length_crc_frame_deframer_test.sv
